// ===== rtl/wwsm_pkg.sv =====
package wwsm_pkg;

  // Default and upper bound of the pattern length.
  localparam int MAX_PATTERN_DEF = 32;

  // Pattern storage is fixed by the register map: four 64-bit words.
  localparam int PAT_WORDS  = 4;
  localparam int PAT_BYTES  = 32;
  localparam int PAT_IDX_W  = 5;
  localparam int PLEN_W     = 6;
  localparam int BLK_W      = 5;

  // Configuration port.
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PAT0  = 3'd0,
    REG_PAT1  = 3'd1,
    REG_PAT2  = 3'd2,
    REG_PAT3  = 3'd3,
    REG_PLEN  = 3'd4,
    REG_WHOLE = 3'd5
  } cfg_reg_t;

  // Line start counts as this non-word character.
  localparam logic [7:0] CHAR_SPACE      = 8'h20;
  localparam logic [7:0] CHAR_UNDERSCORE = 8'h5F;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       line_end;
  } in_word_t;

  // ASCII letters, digits and underscore form words; everything else,
  // including bytes above 127, separates them.
  function automatic logic is_word(input logic [7:0] c);
    return c inside {[8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39], CHAR_UNDERSCORE};
  endfunction

endpackage

// ===== rtl/wwsm_in_if.sv =====
interface wwsm_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] text_byte;
  logic       line_end;

  modport source (output valid, output text_byte, output line_end, input ready);
  modport sink   (input valid, input text_byte, input line_end, output ready);
endinterface

// ===== rtl/wwsm_out_if.sv =====
interface wwsm_out_if;
  logic valid;
  logic ready;
  logic matched;

  modport source (output valid, output matched, input ready);
  modport sink   (input valid, input matched, output ready);
endinterface

// ===== rtl/whole_word_substring_match.sv =====
// Whole-word substring search over text lines. Bytes of a line enter one
// word per cycle on in_chan; the byte flagged with line_end closes the line
// and produces exactly one word on out_chan whose matched bit tells whether
// the configured pattern (1 to MAX_PATTERN bytes) occurs in that line. With
// whole_word set, an occurrence only counts when the bytes on both sides are
// not ASCII letters, digits or underscore; line start and line end count as
// such separators, and a rejected occurrence blocks candidates that start
// within the next pattern_length - 1 positions. The block sustains one byte
// per cycle; only a line end stalls while a result waits on out_chan. Each
// byte is held in an input register and compared in one pass against the
// whole pattern via a window of the last MAX_PATTERN bytes; a line result
// goes to an output register as its last byte leaves the input register.
// Reset needs no clearing pass. The user must write configuration through
// cfg_we/cfg_index/cfg_wdata between lines; the block does not enforce it.
// pattern_length 0 acts as 1, lengths above MAX_PATTERN act as MAX_PATTERN.
module whole_word_substring_match #(
  parameter int MAX_PATTERN = wwsm_pkg::MAX_PATTERN_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  wwsm_in_if.sink                        in_chan,
  wwsm_out_if.source                     out_chan,
  input  logic                           cfg_we,
  input  logic [wwsm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [wwsm_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import wwsm_pkg::*;

  localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
  localparam int SEEN_W = $clog2(MAX_PATTERN + 2);

  // Configuration registers.
  logic [PAT_WORDS-1:0][CFG_DATA_W-1:0] pat_r;
  logic [PLEN_W-1:0]                    plen_r;
  logic                                 whole_r;
  logic [PAT_BYTES-1:0][7:0]            pat_bytes;

  // Input register.
  in_word_t in_r;
  logic     in_valid_r;
  logic     stage_fire;

  // Per-line state.
  logic [MAX_PATTERN-1:0][7:0] win_r;
  logic [SEEN_W-1:0]           seen_r, seen_nxt;
  logic                        found_r, found_nxt;
  logic                        wait_r, wait_nxt;
  logic [BLK_W-1:0]            blk_r, blk_nxt;

  // Result register.
  logic out_valid_r;
  logic out_matched_r;

  // Datapath.
  logic [LEN_W-1:0]          p_len;
  logic [MAX_PATTERN:0][7:0] recent;
  logic [SEEN_W-1:0]         seen_inc;
  logic                      all_eq;
  logic                      occ;
  logic [7:0]                before_byte;
  logic [BLK_W-1:0]          blk_load;
  logic                      line_found;

  assign pat_bytes = pat_r;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pat_r   <= '0;
      plen_r  <= PLEN_W'(1);
      whole_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_PAT0:  pat_r[0] <= cfg_wdata;
        REG_PAT1:  pat_r[1] <= cfg_wdata;
        REG_PAT2:  pat_r[2] <= cfg_wdata;
        REG_PAT3:  pat_r[3] <= cfg_wdata;
        REG_PLEN:  plen_r   <= cfg_wdata[PLEN_W-1:0];
        REG_WHOLE: whole_r  <= cfg_wdata[0];
        default: begin
        end
      endcase
    end
  end

  // Effective pattern length, clamped to 1..MAX_PATTERN.
  always_comb begin
    if (plen_r == '0) begin
      p_len = LEN_W'(1);
    end else if (plen_r > PLEN_W'(MAX_PATTERN)) begin
      p_len = LEN_W'(MAX_PATTERN);
    end else begin
      p_len = plen_r[LEN_W-1:0];
    end
  end

  // A byte that does not end a line never needs the result register, so it
  // moves on even while a result is waiting.
  assign stage_fire    = in_valid_r && (!in_r.line_end || !out_valid_r || out_chan.ready);
  assign in_chan.ready = !in_valid_r || stage_fire;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      in_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_chan.ready && in_chan.valid) begin
      in_r.text_byte <= in_chan.text_byte;
      in_r.line_end  <= in_chan.line_end;
    end
  end

  // Window as it stands after the current byte is shifted in: index 0 is
  // the current byte, index j is the byte j positions back.
  always_comb begin
    recent[0] = in_r.text_byte;
    for (int j = 1; j <= MAX_PATTERN; j++) begin
      recent[j] = win_r[j-1];
    end
  end

  assign seen_inc = (seen_r < SEEN_W'(MAX_PATTERN + 1)) ? seen_r + SEEN_W'(1) : seen_r;

  // The pattern ends at the current byte when recent[j] equals pattern byte
  // p_len-1-j for every j below p_len.
  always_comb begin
    all_eq = 1'b1;
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (LEN_W'(j) < p_len) begin
        if (recent[j] != pat_bytes[PAT_IDX_W'(int'(p_len) - 1 - j)]) begin
          all_eq = 1'b0;
        end
      end
    end
  end

  assign occ         = all_eq && (seen_inc >= SEEN_W'(p_len));
  assign before_byte = (seen_inc > SEEN_W'(p_len)) ? recent[p_len] : CHAR_SPACE;
  assign blk_load    = BLK_W'(int'(p_len) - 1);

  // Next line state for the byte in the input register.
  always_comb begin
    found_nxt = found_r;
    wait_nxt  = wait_r;
    blk_nxt   = blk_r;
    if (!found_r) begin
      if (whole_r) begin
        if (wait_r) begin
          wait_nxt = 1'b0;
          if (!is_word(in_r.text_byte)) begin
            found_nxt = 1'b1;
          end else begin
            blk_nxt = blk_load;
          end
        end
        if (!found_nxt) begin
          if (blk_nxt != '0) begin
            blk_nxt = blk_nxt - BLK_W'(1);
          end else if (occ) begin
            if (!is_word(before_byte)) begin
              wait_nxt = 1'b1;
            end else begin
              blk_nxt = blk_load;
            end
          end
        end
      end else if (occ) begin
        found_nxt = 1'b1;
      end
    end
    // Line end is a separator for an occurrence still waiting on its right.
    line_found = found_nxt || wait_nxt;
    seen_nxt   = seen_inc;
    if (in_r.line_end) begin
      seen_nxt  = '0;
      found_nxt = 1'b0;
      wait_nxt  = 1'b0;
      blk_nxt   = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r  <= '0;
      found_r <= 1'b0;
      wait_r  <= 1'b0;
      blk_r   <= '0;
    end else if (stage_fire) begin
      seen_r  <= seen_nxt;
      found_r <= found_nxt;
      wait_r  <= wait_nxt;
      blk_r   <= blk_nxt;
    end
  end

  // Window bytes are only read where the byte count says they belong to
  // the current line, so they need no reset.
  always_ff @(posedge clk) begin
    if (stage_fire) begin
      win_r <= recent[MAX_PATTERN-1:0];
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (stage_fire && in_r.line_end) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stage_fire && in_r.line_end) begin
      out_matched_r <= line_found;
    end
  end

  assign out_chan.valid   = out_valid_r;
  assign out_chan.matched = out_matched_r;

`ifndef SYNTHESIS
  a_found_excludes_wait: assert property (@(posedge clk) disable iff (!rst_n)
    !(found_r && wait_r))
    else $error("line marked found while an occurrence still waits");

  a_block_excludes_wait: assert property (@(posedge clk) disable iff (!rst_n)
    (blk_r != '0) |-> !wait_r)
    else $error("candidates blocked while an occurrence waits");

  a_result_from_line_end: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(stage_fire && in_r.line_end))
    else $error("result appeared without a line end");

  a_line_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (stage_fire && in_r.line_end) |=> (seen_r == '0 && !found_r && blk_r == '0))
    else $error("line state not cleared after line end");
`endif

endmodule
